>>> hw/rtl/masked_byte_pattern_scan_macros.svh
// ----------------------------------------------------------------------------
// masked_byte_pattern_scan_macros.svh
// Assertion macros shared by the masked byte pattern scanner
// ----------------------------------------------------------------------------
`ifndef MASKED_BYTE_PATTERN_SCAN_MACROS_SVH
`define MASKED_BYTE_PATTERN_SCAN_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define MBPS_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mbps assertion failed");

// consequent must hold in the cycle after the antecedent
`define MBPS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mbps assertion failed");

`endif

>>> hw/rtl/mbps_pkg.sv
// ----------------------------------------------------------------------------
// mbps_pkg
// Types and constants of the masked byte pattern scanner
// ----------------------------------------------------------------------------
package mbps_pkg;

  // pattern storage is always sixteen bytes wide
  localparam int PAT_BYTES = 16;
  localparam int PAT_IDX_W = $clog2(PAT_BYTES);
  // width used for pattern position arithmetic (holds 0..16 and wraps below)
  localparam int POS_W     = PAT_IDX_W + 1;

  typedef logic [7:0] byte_t;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_PATTERN_LOW    = 2'd0,
    CFG_PATTERN_HIGH   = 2'd1,
    CFG_CARE_MASK      = 2'd2,
    CFG_PATTERN_LENGTH = 2'd3
  } cfg_index_t;

  // per-request step from the window chain to the control unit
  typedef struct packed {
    logic accept;
    logic last;
    logic window_hit;
  } step_t;

endpackage

>>> hw/rtl/mbps_cell.sv
// ----------------------------------------------------------------------------
// mbps_cell
// One window cell: holds one byte and compares the byte it takes in
// ----------------------------------------------------------------------------
module mbps_cell #(
  parameter int IDX   = 0,
  parameter int LEN_W = 5
) (
  input  logic                                   clk,
  input  logic                                   advance,
  input  mbps_pkg::byte_t                        byte_in,
  input  logic [LEN_W-1:0]                       len,
  input  mbps_pkg::byte_t                        pattern [mbps_pkg::PAT_BYTES],
  input  logic [mbps_pkg::PAT_BYTES-1:0]         care_mask,
  output mbps_pkg::byte_t                        byte_out,
  output logic                                   hit
);
  import mbps_pkg::*;

  logic [POS_W-1:0]     sel_pos;
  logic [PAT_IDX_W-1:0] sel;
  logic                 in_use;

  // pattern position this cell lines up with: len - 1 - IDX
  assign sel_pos = POS_W'(len) - POS_W'(IDX) - POS_W'(1);
  assign sel     = sel_pos[PAT_IDX_W-1:0];
  assign in_use  = POS_W'(IDX) < POS_W'(len);

  // compare on the byte entering the cell
  assign hit = !in_use || !care_mask[sel] || (byte_in == pattern[sel]);

  // shift stage
  always_ff @(posedge clk) begin
    if (advance) begin
      byte_out <= byte_in;
    end
  end

endmodule

>>> hw/rtl/mbps_ctrl.sv
// ----------------------------------------------------------------------------
// mbps_ctrl
// Region byte count, report flag and registered result stage
// ----------------------------------------------------------------------------
`include "masked_byte_pattern_scan_macros.svh"

module mbps_ctrl #(
  parameter int OFFSET_BITS = 32,
  parameter int LEN_W       = 5
) (
  input  logic                   clk,
  input  logic                   rst,
  input  mbps_pkg::step_t        step,
  input  logic [LEN_W-1:0]       len,
  input  logic                   out_stall,
  output logic                   in_stall,
  output logic                   out_valid,
  output logic                   found,
  output logic [OFFSET_BITS-1:0] match_offset
);
  import mbps_pkg::*;

  logic [OFFSET_BITS-1:0] bytes_seen;
  logic [OFFSET_BITS-1:0] bytes_seen_next;
  logic                   match_reported;
  logic [OFFSET_BITS-1:0] len_ext;
  logic                   fire_match;
  logic                   fire_miss;

  // new request only when the result stage can take it
  assign in_stall = out_valid && out_stall;

  // saturating count including the incoming byte
  assign bytes_seen_next = (bytes_seen == '1) ? bytes_seen
                                              : bytes_seen + OFFSET_BITS'(1);
  assign len_ext         = OFFSET_BITS'(len);

  // one report per region
  assign fire_match = !match_reported && (bytes_seen_next >= len_ext) && step.window_hit;
  assign fire_miss  = !fire_match && step.last && !match_reported;

  // region state
  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_seen     <= '0;
      match_reported <= 1'b0;
    end else if (step.accept) begin
      if (step.last) begin
        bytes_seen     <= '0;
        match_reported <= 1'b0;
      end else begin
        bytes_seen <= bytes_seen_next;
        if (fire_match) begin
          match_reported <= 1'b1;
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step.accept && (fire_match || fire_miss)) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (step.accept && (fire_match || fire_miss)) begin
      found        <= fire_match;
      match_offset <= fire_match ? (bytes_seen_next - len_ext) : '0;
    end
  end

  // checks
  `MBPS_ASSERT_SAME(a_no_overrun, clk, rst, step.accept, !(out_valid && out_stall))
  `MBPS_ASSERT_NEXT(a_region_clear, clk, rst, step.accept && step.last, bytes_seen == '0 && !match_reported)
  `MBPS_ASSERT_NEXT(a_match_flag, clk, rst, step.accept && !step.last && fire_match, match_reported)
  `MBPS_ASSERT_SAME(a_miss_offset, clk, rst, out_valid && !found, match_offset == '0)
  `MBPS_ASSERT_NEXT(a_held_result, clk, rst, out_valid && out_stall, out_valid && $stable(match_offset))

endmodule

>>> hw/rtl/masked_byte_pattern_scan.sv
// ----------------------------------------------------------------------------
// masked_byte_pattern_scan
// Masked byte pattern search over a stream of regions
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one byte of a region per
//   request, with last_byte marking the final byte. Output channel
//   (out_valid / out_stall) carries one result per region: found with the
//   start offset of the first match, or not-found with offset 0 at the
//   region's last byte. Bytes after a match are consumed silently.
//   Configuration (cfg_valid / cfg_ready, cfg_index, cfg_data) writes the
//   pattern, care mask and length; cfg_ready is always high.
//   Throughput is one byte per cycle while in_stall is low: a chain of window
//   cells shifts one byte per request and every cell compares in parallel. A
//   result appears in the cycle after the byte that causes it is accepted.
//   in_stall is high only while a result is held and out_stall is high.
//   Reset clears the region count, the report flag and the result stage
//   and sets pattern and mask to zero and the length to one.
// ----------------------------------------------------------------------------
module masked_byte_pattern_scan #(
  parameter int MAX_PATTERN_BYTES = 16,
  parameter int OFFSET_BITS       = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  // byte requests
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [7:0]             data_byte,
  input  logic                   last_byte,
  // results
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic                   found,
  output logic [OFFSET_BITS-1:0] match_offset,
  // configuration
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  mbps_pkg::cfg_index_t   cfg_index,
  input  logic [63:0]            cfg_data
);
  import mbps_pkg::*;

  localparam int LEN_W = $clog2(MAX_PATTERN_BYTES + 1);

  logic [63:0]          pattern_low;
  logic [63:0]          pattern_high;
  logic [PAT_BYTES-1:0] care_mask;
  logic [4:0]           pattern_length;
  byte_t                pattern [PAT_BYTES];
  logic [LEN_W-1:0]     len;
  byte_t                chain [MAX_PATTERN_BYTES+1];
  logic [MAX_PATTERN_BYTES-1:0] hits;
  logic                 accept;
  step_t                step;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_low    <= '0;
      pattern_high   <= '0;
      care_mask      <= '0;
      pattern_length <= 5'd1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_PATTERN_LOW:    pattern_low    <= cfg_data;
        CFG_PATTERN_HIGH:   pattern_high   <= cfg_data;
        CFG_CARE_MASK:      care_mask      <= cfg_data[PAT_BYTES-1:0];
        CFG_PATTERN_LENGTH: pattern_length <= cfg_data[4:0];
        default: begin
        end
      endcase
    end
  end

  // pattern bytes from the two words
  always_comb begin
    for (int i = 0; i < PAT_BYTES; i++) begin
      if (i < 8) begin
        pattern[i] = pattern_low[8*i +: 8];
      end else begin
        pattern[i] = pattern_high[8*(i-8) +: 8];
      end
    end
  end

  // active length, clamped to 1..MAX_PATTERN_BYTES
  always_comb begin
    if (pattern_length == 5'd0) begin
      len = LEN_W'(1);
    end else if (pattern_length > 5'(MAX_PATTERN_BYTES)) begin
      len = LEN_W'(MAX_PATTERN_BYTES);
    end else begin
      len = LEN_W'(pattern_length);
    end
  end

  assign accept   = in_valid && !in_stall;
  assign chain[0] = data_byte;

  // window chain, newest byte in cell 0
  for (genvar k = 0; k < MAX_PATTERN_BYTES; k++) begin : g_cell
    mbps_cell #(
      .IDX   (k),
      .LEN_W (LEN_W)
    ) u_cell (
      .clk       (clk),
      .advance   (accept),
      .byte_in   (chain[k]),
      .len       (len),
      .pattern   (pattern),
      .care_mask (care_mask),
      .byte_out  (chain[k+1]),
      .hit       (hits[k])
    );
  end

  assign step.accept     = accept;
  assign step.last       = last_byte;
  assign step.window_hit = &hits;

  // region control and result stage
  mbps_ctrl #(
    .OFFSET_BITS (OFFSET_BITS),
    .LEN_W       (LEN_W)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .step         (step),
    .len          (len),
    .out_stall    (out_stall),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .found        (found),
    .match_offset (match_offset)
  );

endmodule
